// File: sv/bpa_pkg.sv
// shared constants, page table entry layout, request and state codes
// for the buddy page allocator; no dependencies
package bpa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int MAX_LEVEL  = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int NUM_LEVELS = MAX_LEVEL + 1;

    localparam int PAGE_W  = $clog2(NUM_PAGES);
    localparam int LINK_W  = PAGE_W + 1;
    localparam int LEVEL_W = 4;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_ADD   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NO_MEM    = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               in_use;
        logic               on_list;
        logic [LINK_W-1:0]  next;
        logic [LINK_W-1:0]  prev;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              re;
        logic              we;
        logic [PAGE_W-1:0] addr;
        entry_t            wdata;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [PAGE_W-1:0]  page;
        logic [LEVEL_W-1:0] level;
    } result_t;

    typedef enum logic [5:0] {
        S_CLEAR,
        S_IDLE,
        S_AL_CHK,
        S_AL_PL,
        S_AL_PR,
        S_AL_MRK_RD,
        S_AL_MRK_WR,
        S_FR_RD,
        S_FR_CHK,
        S_FR_LOOP,
        S_FR_BRD,
        S_FR_BCHK,
        S_FR_HI_RD,
        S_FR_HI_WR,
        S_FR_PUSH,
        S_AD_LOOP,
        S_AD_SET,
        S_AD_RRD,
        S_AD_RWR,
        S_AD_NEXT,
        S_UL_RD,
        S_UL_CHK,
        S_UL_PR,
        S_UL_PRW,
        S_UL_NX,
        S_UL_NXW,
        S_PU_RD,
        S_PU_WR,
        S_PU_TRD,
        S_PU_TWR,
        S_DONE
    } state_t;

endpackage

// File: sv/buddy_page_allocator_core.sv
// top level of the buddy page allocator: sequencer, page table ram and
// registered result port; uses bpa_pkg, bpa_page_ram, bpa_ctrl
//
// usage
//   a request (kind, size_bytes, page_index, end_page, available) is taken
//   at a rising edge with start high and busy low. kind 0 allocates,
//   1 frees the block at page_index, 2 adds the page range
//   [page_index, end_page) as free (available high) or reserved
// results
//   every request gives exactly one result: done is high for one cycle with
//   status, granted_page and granted_level; the receiver cannot stall, so
//   the result must be taken in that cycle. free, add and the unused kind
//   answer status ok with page and level zero
// sequencing
//   one request at a time, at most one ram access per cycle. a rejected alloc
//   or the unused kind goes straight to done; an alloc splits a larger block
//   one level at a time, a free merges with its buddy one level at a time
//   (a double free is answered without a merge), an add carves one aligned
//   block at a time. the next request can be taken while done is high
// reset
//   rst_n clears the list heads and tails at once, then a clearing pass
//   writes every page table entry to zero with busy high
module buddy_page_allocator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       kind,
    input  logic [31:0]                      size_bytes,
    input  logic [bpa_pkg::PAGE_W-1:0]       page_index,
    input  logic [bpa_pkg::LINK_W-1:0]       end_page,
    input  logic                             available,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [bpa_pkg::PAGE_W-1:0]       granted_page,
    output logic [bpa_pkg::LEVEL_W-1:0]      granted_level
);

    bpa_pkg::mem_req_t mem_req;
    bpa_pkg::entry_t   mem_rdata;
    bpa_pkg::result_t  res;

    logic                          done_reg;
    bpa_pkg::status_t              status_reg;
    logic [bpa_pkg::PAGE_W-1:0]    page_reg;
    logic [bpa_pkg::LEVEL_W-1:0]   level_reg;

    // request sequencer with the free list heads and tails
    bpa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .size_bytes (size_bytes),
        .page_index (page_index),
        .end_page   (end_page),
        .available  (available),
        .busy       (busy),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata),
        .res        (res)
    );

    // per-page table: level, in-use, on-list and list links
    bpa_page_ram #(
        .DEPTH (bpa_pkg::NUM_PAGES),
        .WIDTH (bpa_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .re    (mem_req.re),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

    // result register, strobe cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg <= res.status;
            page_reg   <= res.page;
            level_reg  <= res.level;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign granted_page  = page_reg;
    assign granted_level = level_reg;

endmodule

// File: sv/bpa_page_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module bpa_page_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 28
) (
    input  logic                     clk,
    input  logic                     re,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// File: sv/bpa_ctrl.sv
// sequencer of the buddy allocator: free list heads and tails, unlink and
// push micro-routines, read-modify-write of the page table; uses bpa_pkg
module bpa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [1:0]                      kind,
    input  logic [31:0]                     size_bytes,
    input  logic [bpa_pkg::PAGE_W-1:0]      page_index,
    input  logic [bpa_pkg::LINK_W-1:0]      end_page,
    input  logic                            available,
    output logic                            busy,
    output bpa_pkg::mem_req_t               mem_req,
    input  bpa_pkg::entry_t                 mem_rdata,
    output bpa_pkg::result_t                res
);

    localparam int LW = bpa_pkg::LINK_W;
    localparam int VW = bpa_pkg::LEVEL_W;
    localparam int PW = bpa_pkg::PAGE_W;
    localparam logic [VW-1:0] MAXL = VW'(bpa_pkg::MAX_LEVEL);

    bpa_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [LW-1:0] u_reg, u_next, p_reg, p_next, b_reg, b_next, t_reg, t_next;
    logic [LW-1:0] pr_reg, pr_next, nx_reg, nx_next, end_reg, end_next;
    logic [VW-1:0] lvu_reg, lvu_next, plv_reg, plv_next;
    logic [VW-1:0] lv_reg, lv_next, nl_reg, nl_next;
    logic          clr_reg, clr_next, avail_reg, avail_next;
    logic [PW-1:0] clr_cnt_reg, clr_cnt_next;
    bpa_pkg::status_t  status_reg, status_next;
    logic [PW-1:0] gpage_reg, gpage_next;
    logic [VW-1:0] glevel_reg, glevel_next;
    logic [LW-1:0] head_reg [bpa_pkg::NUM_LEVELS];
    logic [LW-1:0] head_next [bpa_pkg::NUM_LEVELS];
    logic [LW-1:0] tail_reg [bpa_pkg::NUM_LEVELS];
    logic [LW-1:0] tail_next [bpa_pkg::NUM_LEVELS];

    // request decode helpers
    logic          too_large;
    logic [VW-1:0] req_lv;
    logic          nl_found;
    logic [VW-1:0] nl_sel;
    logic [VW-1:0] ad_lv;
    logic [VW-1:0] plv_m1;
    logic [LW-1:0] r_page;
    logic [LW-1:0] fr_span, fr_mask, fr_buddy, fr_hi, fr_lo;
    logic          fr_aligned, fr_stop;
    logic [LW-1:0] tail_plv;

    always_comb
    begin
        too_large = {1'b0, size_bytes} >
                    33'(64'(1) << (bpa_pkg::PAGE_SHIFT + bpa_pkg::MAX_LEVEL));
        req_lv = '0;
        for (int l = bpa_pkg::MAX_LEVEL; l >= 0; l--)
        begin
            if ({1'b0, size_bytes} <= 33'(64'(1) << (bpa_pkg::PAGE_SHIFT + l)))
            begin
                req_lv = VW'(l);
            end
        end
    end

    // nearest non-empty level above the requested one
    always_comb
    begin
        nl_found = 1'b0;
        nl_sel   = '0;
        for (int l = bpa_pkg::MAX_LEVEL; l >= 0; l--)
        begin
            if ((VW'(l) > lv_reg) && (head_reg[l] != bpa_pkg::NIL))
            begin
                nl_found = 1'b1;
                nl_sel   = VW'(l);
            end
        end
    end

    // largest aligned block that fits the remaining range
    always_comb
    begin
        ad_lv = '0;
        for (int l = 0; l <= bpa_pkg::MAX_LEVEL; l++)
        begin
            if (({1'b0, p_reg} + (LW+1)'(1 << l) <= {1'b0, end_reg}) &&
                ((p_reg & LW'((1 << l) - 1)) == '0))
            begin
                ad_lv = VW'(l);
            end
        end
    end

    assign plv_m1     = nl_reg - VW'(1);
    assign r_page     = p_reg + (LW'(1) << plv_m1);
    assign fr_span    = LW'(1) << lv_reg;
    assign fr_mask    = (LW'(2) << lv_reg) - LW'(1);
    assign fr_aligned = (p_reg & fr_mask) == '0;
    assign fr_buddy   = fr_aligned ? (p_reg + fr_span) : (p_reg - fr_span);
    assign fr_stop    = (!fr_aligned && (p_reg < fr_span)) || (fr_buddy >= bpa_pkg::NIL);
    assign fr_hi      = (p_reg < b_reg) ? b_reg : p_reg;
    assign fr_lo      = (p_reg < b_reg) ? p_reg : b_reg;
    assign tail_plv   = tail_reg[plv_reg];

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        u_next       = u_reg;
        p_next       = p_reg;
        b_next       = b_reg;
        t_next       = t_reg;
        pr_next      = pr_reg;
        nx_next      = nx_reg;
        end_next     = end_reg;
        lvu_next     = lvu_reg;
        plv_next     = plv_reg;
        lv_next      = lv_reg;
        nl_next      = nl_reg;
        clr_next     = clr_reg;
        avail_next   = avail_reg;
        clr_cnt_next = clr_cnt_reg;
        status_next  = status_reg;
        gpage_next   = gpage_reg;
        glevel_next  = glevel_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + PW'(1);
                if (clr_cnt_reg == PW'(bpa_pkg::NUM_PAGES - 1))
                begin
                    state_next = bpa_pkg::S_IDLE;
                end
            end
            bpa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    status_next = bpa_pkg::ST_OK;
                    gpage_next  = '0;
                    glevel_next = '0;
                    unique case (bpa_pkg::kind_t'(kind))
                        bpa_pkg::KIND_ALLOC:
                        begin
                            if (size_bytes == '0)
                            begin
                                status_next = bpa_pkg::ST_ZERO;
                                state_next  = bpa_pkg::S_DONE;
                            end
                            else if (too_large)
                            begin
                                status_next = bpa_pkg::ST_TOO_LARGE;
                                state_next  = bpa_pkg::S_DONE;
                            end
                            else
                            begin
                                lv_next    = req_lv;
                                state_next = bpa_pkg::S_AL_CHK;
                            end
                        end
                        bpa_pkg::KIND_FREE:
                        begin
                            p_next     = {1'b0, page_index};
                            state_next = bpa_pkg::S_FR_RD;
                        end
                        bpa_pkg::KIND_ADD:
                        begin
                            p_next     = {1'b0, page_index};
                            end_next   = (end_page > bpa_pkg::NIL) ? bpa_pkg::NIL : end_page;
                            avail_next = available;
                            state_next = bpa_pkg::S_AD_LOOP;
                        end
                        bpa_pkg::KIND_NONE:
                        begin
                            state_next = bpa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bpa_pkg::S_AL_CHK:
            begin
                if (head_reg[lv_reg] != bpa_pkg::NIL)
                begin
                    u_next     = head_reg[lv_reg];
                    ret_next   = bpa_pkg::S_AL_MRK_RD;
                    state_next = bpa_pkg::S_UL_RD;
                end
                else if (!nl_found)
                begin
                    status_next = bpa_pkg::ST_NO_MEM;
                    state_next  = bpa_pkg::S_DONE;
                end
                else
                begin
                    u_next     = head_reg[nl_sel];
                    p_next     = head_reg[nl_sel];
                    nl_next    = nl_sel;
                    ret_next   = bpa_pkg::S_AL_PL;
                    state_next = bpa_pkg::S_UL_RD;
                end
            end
            bpa_pkg::S_AL_PL:
            begin
                u_next     = p_reg;
                plv_next   = plv_m1;
                clr_next   = 1'b0;
                ret_next   = bpa_pkg::S_AL_PR;
                state_next = bpa_pkg::S_PU_RD;
            end
            bpa_pkg::S_AL_PR:
            begin
                if (r_page < bpa_pkg::NIL)
                begin
                    u_next     = r_page;
                    plv_next   = plv_m1;
                    clr_next   = 1'b1;
                    ret_next   = bpa_pkg::S_AL_CHK;
                    state_next = bpa_pkg::S_PU_RD;
                end
                else
                begin
                    state_next = bpa_pkg::S_AL_CHK;
                end
            end
            bpa_pkg::S_AL_MRK_RD:
            begin
                state_next = bpa_pkg::S_AL_MRK_WR;
            end
            bpa_pkg::S_AL_MRK_WR:
            begin
                gpage_next  = u_reg[PW-1:0];
                glevel_next = lv_reg;
                state_next  = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_FR_RD:
            begin
                state_next = bpa_pkg::S_FR_CHK;
            end
            bpa_pkg::S_FR_CHK:
            begin
                if (mem_rdata.on_list)
                begin
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    lv_next    = (mem_rdata.level > MAXL) ? MAXL : mem_rdata.level;
                    state_next = bpa_pkg::S_FR_LOOP;
                end
            end
            bpa_pkg::S_FR_LOOP:
            begin
                if ((lv_reg >= MAXL) || fr_stop)
                begin
                    state_next = bpa_pkg::S_FR_PUSH;
                end
                else
                begin
                    b_next     = fr_buddy;
                    state_next = bpa_pkg::S_FR_BRD;
                end
            end
            bpa_pkg::S_FR_BRD:
            begin
                state_next = bpa_pkg::S_FR_BCHK;
            end
            bpa_pkg::S_FR_BCHK:
            begin
                if (mem_rdata.in_use || (mem_rdata.level != lv_reg) || !mem_rdata.on_list)
                begin
                    state_next = bpa_pkg::S_FR_PUSH;
                end
                else
                begin
                    u_next     = b_reg;
                    ret_next   = bpa_pkg::S_FR_HI_RD;
                    state_next = bpa_pkg::S_UL_RD;
                end
            end
            bpa_pkg::S_FR_HI_RD:
            begin
                state_next = bpa_pkg::S_FR_HI_WR;
            end
            bpa_pkg::S_FR_HI_WR:
            begin
                lv_next    = lv_reg + VW'(1);
                p_next     = fr_lo;
                state_next = bpa_pkg::S_FR_LOOP;
            end
            bpa_pkg::S_FR_PUSH:
            begin
                u_next     = p_reg;
                plv_next   = lv_reg;
                clr_next   = 1'b1;
                ret_next   = bpa_pkg::S_DONE;
                state_next = bpa_pkg::S_PU_RD;
            end
            bpa_pkg::S_AD_LOOP:
            begin
                if (p_reg >= end_reg)
                begin
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    lv_next    = ad_lv;
                    u_next     = p_reg;
                    ret_next   = bpa_pkg::S_AD_SET;
                    state_next = bpa_pkg::S_UL_RD;
                end
            end
            bpa_pkg::S_AD_SET:
            begin
                if (avail_reg)
                begin
                    u_next     = p_reg;
                    plv_next   = lv_reg;
                    clr_next   = 1'b1;
                    ret_next   = bpa_pkg::S_AD_NEXT;
                    state_next = bpa_pkg::S_PU_RD;
                end
                else
                begin
                    state_next = bpa_pkg::S_AD_RRD;
                end
            end
            bpa_pkg::S_AD_RRD:
            begin
                state_next = bpa_pkg::S_AD_RWR;
            end
            bpa_pkg::S_AD_RWR:
            begin
                state_next = bpa_pkg::S_AD_NEXT;
            end
            bpa_pkg::S_AD_NEXT:
            begin
                p_next     = p_reg + (LW'(1) << lv_reg);
                state_next = bpa_pkg::S_AD_LOOP;
            end
            bpa_pkg::S_UL_RD:
            begin
                state_next = bpa_pkg::S_UL_CHK;
            end
            bpa_pkg::S_UL_CHK:
            begin
                if (!mem_rdata.on_list || (mem_rdata.level > MAXL))
                begin
                    state_next = ret_reg;
                end
                else
                begin
                    lvu_next   = mem_rdata.level;
                    pr_next    = mem_rdata.prev;
                    nx_next    = mem_rdata.next;
                    state_next = bpa_pkg::S_UL_PR;
                end
            end
            bpa_pkg::S_UL_PR:
            begin
                if (pr_reg < bpa_pkg::NIL)
                begin
                    state_next = bpa_pkg::S_UL_PRW;
                end
                else
                begin
                    head_next[lvu_reg] = nx_reg;
                    state_next         = bpa_pkg::S_UL_NX;
                end
            end
            bpa_pkg::S_UL_PRW:
            begin
                state_next = bpa_pkg::S_UL_NX;
            end
            bpa_pkg::S_UL_NX:
            begin
                if (nx_reg < bpa_pkg::NIL)
                begin
                    state_next = bpa_pkg::S_UL_NXW;
                end
                else
                begin
                    tail_next[lvu_reg] = pr_reg;
                    state_next         = ret_reg;
                end
            end
            bpa_pkg::S_UL_NXW:
            begin
                state_next = ret_reg;
            end
            bpa_pkg::S_PU_RD:
            begin
                state_next = bpa_pkg::S_PU_WR;
            end
            bpa_pkg::S_PU_WR:
            begin
                tail_next[plv_reg] = u_reg;
                if (tail_plv < bpa_pkg::NIL)
                begin
                    t_next     = tail_plv;
                    state_next = bpa_pkg::S_PU_TRD;
                end
                else
                begin
                    head_next[plv_reg] = u_reg;
                    state_next         = ret_reg;
                end
            end
            bpa_pkg::S_PU_TRD:
            begin
                state_next = bpa_pkg::S_PU_TWR;
            end
            bpa_pkg::S_PU_TWR:
            begin
                state_next = ret_reg;
            end
            bpa_pkg::S_DONE:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    // memory requests and status outputs
    always_comb
    begin
        mem_req       = '0;
        mem_req.wdata = mem_rdata;
        busy          = (state_reg != bpa_pkg::S_IDLE);
        res.valid     = (state_reg == bpa_pkg::S_DONE);
        res.status    = status_reg;
        res.page      = gpage_reg;
        res.level     = glevel_reg;
        unique case (state_reg)
            bpa_pkg::S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_cnt_reg;
                mem_req.wdata = '0;
            end
            bpa_pkg::S_AL_MRK_RD, bpa_pkg::S_UL_RD, bpa_pkg::S_PU_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = u_reg[PW-1:0];
            end
            bpa_pkg::S_AL_MRK_WR:
            begin
                mem_req.we           = 1'b1;
                mem_req.addr         = u_reg[PW-1:0];
                mem_req.wdata.in_use = 1'b1;
            end
            bpa_pkg::S_FR_RD, bpa_pkg::S_AD_RRD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = p_reg[PW-1:0];
            end
            bpa_pkg::S_FR_CHK:
            begin
                mem_req.we           = !mem_rdata.on_list;
                mem_req.addr         = p_reg[PW-1:0];
                mem_req.wdata.in_use = 1'b0;
            end
            bpa_pkg::S_FR_BRD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = b_reg[PW-1:0];
            end
            bpa_pkg::S_FR_HI_RD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = fr_hi[PW-1:0];
            end
            bpa_pkg::S_FR_HI_WR:
            begin
                mem_req.we            = 1'b1;
                mem_req.addr          = fr_hi[PW-1:0];
                mem_req.wdata.level   = '0;
                mem_req.wdata.in_use  = 1'b0;
                mem_req.wdata.on_list = 1'b0;
            end
            bpa_pkg::S_AD_RWR:
            begin
                mem_req.we           = 1'b1;
                mem_req.addr         = p_reg[PW-1:0];
                mem_req.wdata.level  = lv_reg;
                mem_req.wdata.in_use = 1'b1;
            end
            bpa_pkg::S_UL_CHK:
            begin
                mem_req.we            = mem_rdata.on_list && (mem_rdata.level <= MAXL);
                mem_req.addr          = u_reg[PW-1:0];
                mem_req.wdata.on_list = 1'b0;
            end
            bpa_pkg::S_UL_PR:
            begin
                mem_req.re   = (pr_reg < bpa_pkg::NIL);
                mem_req.addr = pr_reg[PW-1:0];
            end
            bpa_pkg::S_UL_PRW:
            begin
                mem_req.we         = 1'b1;
                mem_req.addr       = pr_reg[PW-1:0];
                mem_req.wdata.next = nx_reg;
            end
            bpa_pkg::S_UL_NX:
            begin
                mem_req.re   = (nx_reg < bpa_pkg::NIL);
                mem_req.addr = nx_reg[PW-1:0];
            end
            bpa_pkg::S_UL_NXW:
            begin
                mem_req.we         = 1'b1;
                mem_req.addr       = nx_reg[PW-1:0];
                mem_req.wdata.prev = pr_reg;
            end
            bpa_pkg::S_PU_WR:
            begin
                mem_req.we            = 1'b1;
                mem_req.addr          = u_reg[PW-1:0];
                mem_req.wdata.level   = plv_reg;
                mem_req.wdata.in_use  = clr_reg ? 1'b0 : mem_rdata.in_use;
                mem_req.wdata.on_list = 1'b1;
                mem_req.wdata.next    = bpa_pkg::NIL;
                mem_req.wdata.prev    = tail_plv;
            end
            bpa_pkg::S_PU_TRD:
            begin
                mem_req.re   = 1'b1;
                mem_req.addr = t_reg[PW-1:0];
            end
            bpa_pkg::S_PU_TWR:
            begin
                mem_req.we         = 1'b1;
                mem_req.addr       = t_reg[PW-1:0];
                mem_req.wdata.next = u_reg;
            end
            default:
            begin
                mem_req.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bpa_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
            for (int l = 0; l < bpa_pkg::NUM_LEVELS; l++)
            begin
                head_reg[l] <= bpa_pkg::NIL;
                tail_reg[l] <= bpa_pkg::NIL;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        u_reg      <= u_next;
        p_reg      <= p_next;
        b_reg      <= b_next;
        t_reg      <= t_next;
        pr_reg     <= pr_next;
        nx_reg     <= nx_next;
        end_reg    <= end_next;
        lvu_reg    <= lvu_next;
        plv_reg    <= plv_next;
        lv_reg     <= lv_next;
        nl_reg     <= nl_next;
        clr_reg    <= clr_next;
        avail_reg  <= avail_next;
        status_reg <= status_next;
        gpage_reg  <= gpage_next;
        glevel_reg <= glevel_next;
    end

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.re && mem_req.we))
        else $error("page table read and write in one cycle");

    a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && state_reg == bpa_pkg::S_IDLE) |=> (state_reg != bpa_pkg::S_IDLE))
        else $error("accepted request did not start");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |=> (!res.valid && state_reg == bpa_pkg::S_IDLE))
        else $error("result strobe longer than one cycle");

    a_tail_link_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bpa_pkg::S_PU_TRD) |-> (t_reg != bpa_pkg::NIL))
        else $error("push follows a null tail");

endmodule
